// ----- rtl/slcfp_pkg.sv -----
// Shared types, constants and helpers for the sync/length command frame parser.
`timescale 1ns / 1ps

package slcfp_pkg;

  localparam logic [7:0] MIN_LENGTH = 8'h06;
  localparam logic [8:0] END_OFFSET = 9'h003;
  localparam logic [8:0] DATA_START = 9'h009;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd34;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd105;

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    REQ_BYTE    = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef enum logic [10:0] {
    PH_SYNC0  = 11'b000_0000_0001,
    PH_SYNC1  = 11'b000_0000_0010,
    PH_LEN    = 11'b000_0000_0100,
    PH_HW_LO  = 11'b000_0000_1000,
    PH_HW_HI  = 11'b000_0001_0000,
    PH_MSG_LO = 11'b000_0010_0000,
    PH_MSG_HI = 11'b000_0100_0000,
    PH_DEST   = 11'b000_1000_0000,
    PH_OP     = 11'b001_0000_0000,
    PH_DATA   = 11'b010_0000_0000,
    PH_DONE   = 11'b100_0000_0000
  } phase_e;

  localparam logic [3:0] CODE_SYNC0  = 4'd0;
  localparam logic [3:0] CODE_SYNC1  = 4'd1;
  localparam logic [3:0] CODE_LEN    = 4'd2;
  localparam logic [3:0] CODE_HW_LO  = 4'd3;
  localparam logic [3:0] CODE_HW_HI  = 4'd4;
  localparam logic [3:0] CODE_MSG_LO = 4'd5;
  localparam logic [3:0] CODE_MSG_HI = 4'd6;
  localparam logic [3:0] CODE_DEST   = 4'd7;
  localparam logic [3:0] CODE_OP     = 4'd8;
  localparam logic [3:0] CODE_DATA   = 4'd9;
  localparam logic [3:0] CODE_DONE   = 4'd10;

  typedef struct packed {
    phase_e      phase;
    logic [8:0]  write_pos;
    logic [8:0]  end_pos;
    logic [7:0]  length;
    logic [15:0] hwid;
    logic [15:0] msgid;
    logic [7:0]  dest;
    logic [7:0]  opcode;
  } parse_state_t;

  // Declared from the highest bit down, so parse_phase lands in bits 3:0.
  typedef struct packed {
    logic        pad;
    logic [7:0]  command_code;
    logic [7:0]  destination;
    logic [15:0] message_id;
    logic [15:0] hardware_id;
    logic [7:0]  frame_length;
    logic        frame_done;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        payload_valid;
    logic        frame_abort;
    logic [3:0]  parse_phase;
  } result_t;

  function automatic logic [3:0] phase_code(input phase_e ph);
    logic [3:0] code;
    code = CODE_SYNC0;
    unique case (ph)
      PH_SYNC0:  code = CODE_SYNC0;
      PH_SYNC1:  code = CODE_SYNC1;
      PH_LEN:    code = CODE_LEN;
      PH_HW_LO:  code = CODE_HW_LO;
      PH_HW_HI:  code = CODE_HW_HI;
      PH_MSG_LO: code = CODE_MSG_LO;
      PH_MSG_HI: code = CODE_MSG_HI;
      PH_DEST:   code = CODE_DEST;
      PH_OP:     code = CODE_OP;
      PH_DATA:   code = CODE_DATA;
      PH_DONE:   code = CODE_DONE;
      default:   code = CODE_SYNC0;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/sync_length_command_frame_parser_top.sv -----
// Top level of the sync/length command frame parser with stream ports.
//
//  channel   direction  sideband  data
//  s_axis    in         tuser     tdata = rx_byte, tuser = req_type
//  m_axis    out        -         tdata = parse result fields (80 bits)
//  cfg       in         -         cfg_we_i / cfg_idx_i / cfg_data_i
//
// One input item is taken per cycle while s_axis_tready is high and yields
// exactly one result item. The frame state advances in the cycle the item
// is accepted; its result is registered in the output register or skid stage.
// A skid stage keeps s_axis_tready high for one more item under a stall.
// Reset clears the frame state and loads the default sync bytes.
`timescale 1ns / 1ps

module sync_length_command_frame_parser_top import slcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] parse_phase, [4] frame_abort, [5] payload_valid, [13:6] payload_index,
  // [21:14] payload_byte, [22] frame_done, [30:23] frame_length,
  // [46:31] hardware_id, [62:47] message_id, [70:63] destination,
  // [78:71] command_code, [79] zero
  output logic [79:0] m_axis_tdata
);

  logic [7:0]   sync_first_q;
  logic [7:0]   sync_second_q;
  parse_state_t state_q, state_d;
  result_t      res;
  result_t      out_res;
  logic         in_acc;
  req_type_e    req;

  assign req    = req_type_e'(s_axis_tuser[0]);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  slcfp_step u_step (
    .cur_i         (state_q),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .req_i         (req),
    .byte_i        (s_axis_tdata),
    .nxt_o         (state_d),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PH_SYNC0;
      state_q.write_pos <= '0;
      state_q.end_pos   <= '0;
      state_q.length    <= '0;
      state_q.hwid      <= '0;
      state_q.msgid     <= '0;
      state_q.dest      <= '0;
      state_q.opcode    <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  slcfp_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = out_res;

  a_release_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req == REQ_RELEASE) |=> (state_q.phase == PH_SYNC0))
    else $error("release item did not re-arm the sync hunt");

  a_data_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_DATA) |-> (state_q.write_pos < state_q.end_pos))
    else $error("data phase entered with no payload room left");

  a_abort_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_res.frame_abort && out_res.payload_valid))
    else $error("result flags both an abort and a payload byte");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req == REQ_BYTE && state_q.phase == PH_DONE) |=> $stable(state_q))
    else $error("byte changed the state of a held frame");

endmodule

// ----- rtl/slcfp_step.sv -----
// Per-byte parser step: next frame state and the result item for one input item.
`timescale 1ns / 1ps

module slcfp_step import slcfp_pkg::*; (
  input  parse_state_t cur_i,
  input  logic [7:0]   sync_first_i,
  input  logic [7:0]   sync_second_i,
  input  req_type_e    req_i,
  input  logic [7:0]   byte_i,
  output parse_state_t nxt_o,
  output result_t      res_o
);

  logic       abort;
  logic       pv;
  logic [7:0] pidx;
  logic [7:0] pbyte;
  logic [8:0] wp_inc;

  assign wp_inc = cur_i.write_pos + 9'd1;

  always_comb begin
    nxt_o = cur_i;
    abort = 1'b0;
    pv    = 1'b0;
    pidx  = '0;
    pbyte = '0;
    if (req_i == REQ_RELEASE) begin
      nxt_o.phase     = PH_SYNC0;
      nxt_o.write_pos = '0;
      nxt_o.end_pos   = '0;
    end else begin
      unique case (cur_i.phase)
        PH_SYNC0: begin
          if (byte_i == sync_first_i) nxt_o.phase = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (byte_i == sync_second_i) begin
            nxt_o.phase = PH_LEN;
          end else begin
            nxt_o.phase     = PH_SYNC0;
            nxt_o.write_pos = '0;
            nxt_o.end_pos   = '0;
            abort           = 1'b1;
          end
        end
        PH_LEN: begin
          if (byte_i >= MIN_LENGTH) begin
            nxt_o.length    = byte_i;
            nxt_o.write_pos = DATA_START;
            nxt_o.end_pos   = {1'b0, byte_i} + END_OFFSET;
            nxt_o.phase     = PH_HW_LO;
          end else begin
            nxt_o.phase     = PH_SYNC0;
            nxt_o.write_pos = '0;
            nxt_o.end_pos   = '0;
            abort           = 1'b1;
          end
        end
        PH_HW_LO: begin
          nxt_o.hwid[7:0] = byte_i;
          nxt_o.phase     = PH_HW_HI;
        end
        PH_HW_HI: begin
          nxt_o.hwid[15:8] = byte_i;
          nxt_o.phase      = PH_MSG_LO;
        end
        PH_MSG_LO: begin
          nxt_o.msgid[7:0] = byte_i;
          nxt_o.phase      = PH_MSG_HI;
        end
        PH_MSG_HI: begin
          nxt_o.msgid[15:8] = byte_i;
          nxt_o.phase       = PH_DEST;
        end
        PH_DEST: begin
          nxt_o.dest  = byte_i;
          nxt_o.phase = PH_OP;
        end
        PH_OP: begin
          nxt_o.opcode = byte_i;
          nxt_o.phase  = (cur_i.write_pos < cur_i.end_pos) ? PH_DATA : PH_DONE;
        end
        PH_DATA: begin
          if (cur_i.write_pos < cur_i.end_pos) begin
            pv              = 1'b1;
            pidx            = 8'(cur_i.write_pos - DATA_START);
            pbyte           = byte_i;
            nxt_o.write_pos = wp_inc;
          end
          if (nxt_o.write_pos == cur_i.end_pos) nxt_o.phase = PH_DONE;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o               = '0;
    res_o.parse_phase   = phase_code(nxt_o.phase);
    res_o.frame_abort   = abort;
    res_o.payload_valid = pv;
    res_o.payload_index = pidx;
    res_o.payload_byte  = pbyte;
    res_o.frame_done    = (nxt_o.phase == PH_DONE);
    res_o.frame_length  = nxt_o.length;
    res_o.hardware_id   = nxt_o.hwid;
    res_o.message_id    = nxt_o.msgid;
    res_o.destination   = nxt_o.dest;
    res_o.command_code  = nxt_o.opcode;
  end

endmodule

// ----- rtl/slcfp_out_skid.sv -----
// Output register with a skid stage for result items.
`timescale 1ns / 1ps

module slcfp_out_skid import slcfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    in_acc;
  logic    out_free;

  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = in_data_i;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item did not move to the output register");

endmodule
